/* design/lms_pkg.sv */
// Shared types and constants for the lattice Metropolis site update block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package lms_pkg;

  // Fixed field widths.
  localparam int SITE_W  = 10;  // site index on the ports
  localparam int VAL_W   = 16;  // Q4.12 site value
  localparam int THR_W   = 20;  // Q8.12 threshold and 1/(4a)
  localparam int CHG_W   = 32;  // Q20.12 action change
  localparam int CFG_AW  = 4;   // APB byte address width
  localparam int CFG_DW  = 32;  // APB data width

  // Shared multiplier: a 37-bit operand times a 20-bit operand.
  localparam int MUL_AW  = 37;
  localparam int MUL_BW  = 20;
  localparam int PROD_W  = MUL_AW + MUL_BW;

  // Action difference accumulator in Q.36; every term stays below 2^53.
  localparam int ACC_W   = 56;
  localparam int TERM_W  = 53;

  // Last step of the restoring index reduction (one bit of the site per step).
  localparam logic [3:0] RED_TOP = 4'(SITE_W - 1);

  // Last micro step of one local action evaluation.
  localparam logic [2:0] STEP_LAST = 3'd6;

  // Function codes of a request.
  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_PROPOSE = 2'd1,
    FN_READ    = 2'd2,
    FN_SPARE   = 2'd3
  } func_t;

  // Register indexes on the configuration port (address bits 3:2).
  typedef enum logic [1:0] {
    REG_SPACING  = 2'd0,
    REG_INV_FOUR = 2'd1,
    REG_WELL_SQ  = 2'd2,
    REG_COOLING  = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [VAL_W-1:0] SPACING_RST  = 16'd205;
  localparam logic [THR_W-1:0] INV_FOUR_RST = 20'd20480;
  localparam logic [VAL_W-1:0] WELL_SQ_RST  = 16'd8028;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_START,
    S_RD,
    S_P_L,
    S_P_R,
    S_P_C,
    S_CALC,
    S_DECIDE,
    S_EMIT
  } state_t;

endpackage

/* design/lattice_metropolis_site_update.sv */
// Top level of the lattice Metropolis site update block: site memory, sequencer and
// one shared multiplier. Depends on lms_pkg.
`timescale 1ns / 1ps

// The block keeps a ring of SITES signed Q4.12 values in a memory with one read and one
// write port and serves one request at a time: in_ready is high only while the sequencer
// is idle. A proposal makes three memory reads of the left, right and centre sites, then
// twelve products through the one shared 37x20 multiplier (six for the action at the
// proposed value, six at the old value) with the product registered after each, a decision
// step that writes back an accepted value, and a result step. A site index at or beyond
// SITES is first reduced by a restoring loop. A finished result waits in the output
// register; the next request is taken while it waits, and the following result is held
// back until the output is free. The memory has no reset; a site must be loaded before it
// is read or used as a neighbor.
module lattice_metropolis_site_update #(
  parameter int SITES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [lms_pkg::SITE_W-1:0]    in_site,
  input  logic signed [lms_pkg::VAL_W-1:0] in_load_value,
  input  logic signed [lms_pkg::VAL_W-1:0] in_offset,
  input  logic [lms_pkg::THR_W-1:0]     in_threshold,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lms_pkg::SITE_W-1:0]    out_site,
  output logic signed [lms_pkg::VAL_W-1:0] out_site_value,
  output logic                          out_accepted,
  output logic signed [lms_pkg::CHG_W-1:0] out_action_change,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lms_pkg::CFG_AW-1:0]    paddr,
  input  logic [lms_pkg::CFG_DW-1:0]    pwdata,
  output logic [lms_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import lms_pkg::*;

  localparam int IDX_W = $clog2(SITES);
  localparam int RED_W = SITE_W + 17;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SITES - 1);

  // Configuration registers
  logic [VAL_W-1:0] spacing_r;
  logic [THR_W-1:0] inv_four_r;
  logic [VAL_W-1:0] well_sq_r;
  logic             cooling_r;

  // Sequencer and datapath registers
  state_t                    state_r, state_nxt;
  func_t                     func_r, func_nxt;
  logic [SITE_W-1:0]         rem_r, rem_nxt;
  logic [3:0]                red_r, red_nxt;
  logic signed [VAL_W-1:0]   load_r, load_nxt;
  logic signed [VAL_W-1:0]   offset_r, offset_nxt;
  logic [THR_W-1:0]          thr_r, thr_nxt;
  logic signed [VAL_W-1:0]   l_r, l_nxt;
  logic signed [VAL_W-1:0]   r_r, r_nxt;
  logic signed [VAL_W-1:0]   xo_r, xo_nxt;
  logic signed [VAL_W-1:0]   xn_r, xn_nxt;
  logic                      phase_r, phase_nxt;
  logic [2:0]                step_r, step_nxt;
  logic [PROD_W-1:0]         mul_r, mul_nxt;
  logic [32:0]               sq_r, sq_nxt;
  logic signed [THR_W-1:0]   w_r, w_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [VAL_W-1:0]   res_value_r, res_value_nxt;
  logic                      res_acc_r, res_acc_nxt;
  logic signed [CHG_W-1:0]   res_chg_r, res_chg_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SITE_W-1:0]         out_site_r, out_site_nxt;
  logic signed [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic                      out_acc_r, out_acc_nxt;
  logic signed [CHG_W-1:0]   out_chg_r, out_chg_nxt;

  // Site memory
  logic signed [VAL_W-1:0]   mem [SITES];
  logic signed [VAL_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]          mem_raddr;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic signed [VAL_W-1:0]   mem_wdata;

  // Combinational helpers
  logic [IDX_W-1:0]          cur_idx, idx_left, idx_right;
  logic [RED_W-1:0]          red_mod;
  logic signed [VAL_W-1:0]   x_cur;
  logic signed [VAL_W:0]     d_left, d_right, x_sum;
  logic [VAL_W-1:0]          d_left_abs, d_right_abs, x_abs;
  logic [THR_W-1:0]          w_abs;
  logic [MUL_AW-1:0]         mul_a;
  logic [MUL_BW-1:0]         mul_b;
  logic signed [ACC_W-1:0]   term, thr_ext;
  logic signed [VAL_W-1:0]   xn_sat;
  logic                      move_ok;
  logic                      cfg_wr;

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_site          = out_site_r;
  assign out_site_value    = out_value_r;
  assign out_accepted      = out_acc_r;
  assign out_action_change = out_chg_r;
  assign pready            = 1'b1;

  // ---------------- Configuration port ----------------
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r  <= SPACING_RST;
      inv_four_r <= INV_FOUR_RST;
      well_sq_r  <= WELL_SQ_RST;
      cooling_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SPACING:  spacing_r  <= pwdata[VAL_W-1:0];
        REG_INV_FOUR: inv_four_r <= pwdata[THR_W-1:0];
        REG_WELL_SQ:  well_sq_r  <= pwdata[VAL_W-1:0];
        REG_COOLING:  cooling_r  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SPACING:  prdata = CFG_DW'(spacing_r);
      REG_INV_FOUR: prdata = CFG_DW'(inv_four_r);
      REG_WELL_SQ:  prdata = CFG_DW'(well_sq_r);
      REG_COOLING:  prdata = CFG_DW'(cooling_r);
    endcase
  end

  // ---------------- Site memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------- Index arithmetic ----------------
  assign cur_idx   = IDX_W'(rem_r);
  assign idx_left  = (cur_idx == '0) ? IDX_LAST : cur_idx - IDX_W'(1);
  assign idx_right = (cur_idx == IDX_LAST) ? '0 : cur_idx + IDX_W'(1);
  assign red_mod   = RED_W'(SITES) << red_r;

  // ---------------- Shared multiplier operands ----------------
  assign x_cur       = phase_r ? xo_r : xn_r;
  assign d_left      = {x_cur[VAL_W-1], x_cur} - {l_r[VAL_W-1], l_r};
  assign d_right     = {r_r[VAL_W-1], r_r} - {x_cur[VAL_W-1], x_cur};
  assign d_left_abs  = d_left[VAL_W]  ? VAL_W'(-d_left)  : VAL_W'(d_left);
  assign d_right_abs = d_right[VAL_W] ? VAL_W'(-d_right) : VAL_W'(d_right);
  assign x_abs       = x_cur[VAL_W-1] ? VAL_W'(-{x_cur[VAL_W-1], x_cur}) : VAL_W'(x_cur);
  assign w_abs       = w_r[THR_W-1] ? THR_W'(-w_r) : THR_W'(w_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      3'd0: begin
        mul_a = MUL_AW'(d_left_abs);
        mul_b = MUL_BW'(d_left_abs);
      end
      3'd1: begin
        mul_a = MUL_AW'(d_right_abs);
        mul_b = MUL_BW'(d_right_abs);
      end
      3'd2: begin
        mul_a = MUL_AW'(x_abs);
        mul_b = MUL_BW'(x_abs);
      end
      3'd3: begin
        mul_a = MUL_AW'(sq_r);
        mul_b = inv_four_r;
      end
      3'd4: begin
        mul_a = MUL_AW'(w_abs);
        mul_b = w_abs;
      end
      3'd5: begin
        mul_a = mul_r[MUL_AW-1:0];
        mul_b = MUL_BW'(spacing_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Kinetic and potential terms are added for the new value and subtracted for the old.
  assign term    = $signed({{(ACC_W-TERM_W){1'b0}}, mul_r[TERM_W-1:0]});
  assign thr_ext = $signed({{(ACC_W-THR_W-24){1'b0}}, thr_r, 24'd0});
  assign move_ok = cooling_r ? (acc_r <= 0) : (acc_r <= thr_ext);

  assign x_sum  = {rd_data_r[VAL_W-1], rd_data_r} + {offset_r[VAL_W-1], offset_r};
  assign xn_sat = (x_sum[VAL_W] != x_sum[VAL_W-1])
                  ? (x_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}})
                  : x_sum[VAL_W-1:0];

  // ---------------- Sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    rem_r       <= rem_nxt;
    red_r       <= red_nxt;
    load_r      <= load_nxt;
    offset_r    <= offset_nxt;
    thr_r       <= thr_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    xo_r        <= xo_nxt;
    xn_r        <= xn_nxt;
    phase_r     <= phase_nxt;
    step_r      <= step_nxt;
    mul_r       <= mul_nxt;
    sq_r        <= sq_nxt;
    w_r         <= w_nxt;
    acc_r       <= acc_nxt;
    res_value_r <= res_value_nxt;
    res_acc_r   <= res_acc_nxt;
    res_chg_r   <= res_chg_nxt;
    out_site_r  <= out_site_nxt;
    out_value_r <= out_value_nxt;
    out_acc_r   <= out_acc_nxt;
    out_chg_r   <= out_chg_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    rem_nxt       = rem_r;
    red_nxt       = red_r;
    load_nxt      = load_r;
    offset_nxt    = offset_r;
    thr_nxt       = thr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    xo_nxt        = xo_r;
    xn_nxt        = xn_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    mul_nxt       = PROD_W'(mul_a) * PROD_W'(mul_b);
    sq_nxt        = sq_r;
    w_nxt         = w_r;
    acc_nxt       = acc_r;
    res_value_nxt = res_value_r;
    res_acc_nxt   = res_acc_r;
    res_chg_nxt   = res_chg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_site_nxt  = out_site_r;
    out_value_nxt = out_value_r;
    out_acc_nxt   = out_acc_r;
    out_chg_nxt   = out_chg_r;
    mem_raddr     = cur_idx;
    mem_we        = 1'b0;
    mem_waddr     = cur_idx;
    mem_wdata     = load_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = func_t'(in_func);
          rem_nxt    = in_site;
          red_nxt    = RED_TOP;
          load_nxt   = in_load_value;
          offset_nxt = in_offset;
          thr_nxt    = in_threshold;
          state_nxt  = (32'(in_site) >= 32'(SITES)) ? S_REDUCE : S_START;
        end
      end

      // Restoring reduction of the site index, one quotient bit per cycle.
      S_REDUCE: begin
        if (RED_W'(rem_r) >= red_mod) begin
          rem_nxt = SITE_W'(RED_W'(rem_r) - red_mod);
        end
        red_nxt = red_r - 4'd1;
        if (red_r == '0) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_acc_nxt = 1'b0;
        res_chg_nxt = '0;
        unique case (func_r)
          FN_LOAD: begin
            mem_we        = 1'b1;
            res_value_nxt = load_r;
            state_nxt     = S_EMIT;
          end
          FN_PROPOSE: begin
            mem_raddr = idx_left;
            state_nxt = S_P_L;
          end
          FN_READ, FN_SPARE: begin
            state_nxt = S_RD;
          end
        endcase
      end

      S_RD: begin
        res_value_nxt = rd_data_r;
        state_nxt     = S_EMIT;
      end

      S_P_L: begin
        l_nxt     = rd_data_r;
        mem_raddr = idx_right;
        state_nxt = S_P_R;
      end

      S_P_R: begin
        r_nxt     = rd_data_r;
        state_nxt = S_P_C;
      end

      S_P_C: begin
        xo_nxt    = rd_data_r;
        xn_nxt    = xn_sat;
        acc_nxt   = '0;
        phase_nxt = 1'b0;
        step_nxt  = '0;
        state_nxt = S_CALC;
      end

      // Steps 0..2 square the differences and the value; step 3 forms the well offset
      // and scales the kinetic sum; steps 4..6 square and scale the well term.
      S_CALC: begin
        unique case (step_r)
          3'd1: sq_nxt = {1'b0, mul_r[31:0]};
          3'd2: sq_nxt = sq_r + {1'b0, mul_r[31:0]};
          3'd3: w_nxt  = $signed({1'b0, mul_r[30:12]}) - $signed({4'd0, well_sq_r});
          3'd4, 3'd6: acc_nxt = phase_r ? acc_r - term : acc_r + term;
          default: ;
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          phase_nxt = 1'b1;
          if (phase_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      // The floored Q.12 difference always fits in 32 bits, so it never saturates.
      S_DECIDE: begin
        mem_we        = move_ok;
        mem_wdata     = xn_r;
        res_value_nxt = move_ok ? xn_r : xo_r;
        res_acc_nxt   = move_ok;
        res_chg_nxt   = acc_r[ACC_W-1:ACC_W-CHG_W];
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_site_nxt  = rem_r;
          out_value_nxt = res_value_r;
          out_acc_nxt   = res_acc_r;
          out_chg_nxt   = res_chg_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* design/lms_checker.sv */
// Port-level checker for the lattice Metropolis site update block, bound to its top level.
// Depends on lms_pkg for field widths.
`timescale 1ns / 1ps

module lms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lms_pkg::SITE_W-1:0]        out_site,
  input logic signed [lms_pkg::VAL_W-1:0]  out_site_value,
  input logic                              out_accepted,
  input logic signed [lms_pkg::CHG_W-1:0]  out_action_change
);
  import lms_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_site) && $stable(out_site_value)
      && $stable(out_accepted) && $stable(out_action_change))
    else $error("result changed while stalled");

  // Only one request is in flight: the block is busy right after taking one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // A new result appears only at the end of a request, while no request is taken.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in work");

  // A move that lowers the action is always kept, in either mode.
  a_downhill_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action_change[CHG_W-1] |-> out_accepted)
    else $error("move with negative action change was rejected");

endmodule

bind lattice_metropolis_site_update lms_checker u_lms_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_site          (out_site),
  .out_site_value    (out_site_value),
  .out_accepted      (out_accepted),
  .out_action_change (out_action_change)
);
